@@ src/tq_pkg.sv @@
// Team queue package: command and status codes, field widths and the
// structs that join the controller to the datapath. No dependencies.
package tq_pkg;

    localparam int CMD_W  = 2;
    localparam int MEM_W  = 10;
    localparam int TEAM_W = 4;
    localparam int STAT_W = 2;

    // Beat widths on the stream ports
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = CMD_W;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = STAT_W + 1;

    localparam logic [CMD_W-1:0] CMD_ASSIGN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENQ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEQ    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic              load;
        logic              enq_alloc;
        logic              enq_link;
        logic              deq_team;
        logic              deq_slot;
        logic              deq_pop;
        logic              res_we;
        logic              res_member;
        logic [STAT_W-1:0] res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic             full;
        logic             empty;
        logic             team_active;
        logic             out_free;
    } t_dp_stat;

endpackage

@@ src/tq_datapath.sv @@
// Team queue datapath: member map, team head/tail tables, slot pool with
// link memory, free slot stack, team order FIFO and the result register.
// Depends on tq_pkg.
module tq_datapath #(
    parameter int MAX_TEAMS  = 16,
    parameter int MEMBER_IDS = 1024,
    parameter int CAPACITY   = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tq_pkg::t_dp_cmd                i_cmd,
    output tq_pkg::t_dp_stat               o_stat,
    input  logic [tq_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic [tq_pkg::IN_USER_W-1:0]   i_in_user,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [tq_pkg::OUT_DATA_W-1:0]  o_out_data,
    output logic [tq_pkg::OUT_USER_W-1:0]  o_out_user
);

    localparam int TW = (MAX_TEAMS > 1) ? $clog2(MAX_TEAMS) : 1;
    localparam int OW = $clog2(MAX_TEAMS + 1);
    localparam int MW = (MEMBER_IDS > 1) ? $clog2(MEMBER_IDS) : 1;
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [TW-1:0] member_team [MEMBER_IDS];
    logic [SW-1:0] team_head   [MAX_TEAMS];
    logic [SW-1:0] team_tail   [MAX_TEAMS];
    logic [TW-1:0] order_fifo  [MAX_TEAMS];
    logic [SW-1:0] next_link   [CAPACITY];
    logic [tq_pkg::MEM_W-1:0] slot_member [CAPACITY];
    logic [SW-1:0] free_stack  [CAPACITY];

    logic [MAX_TEAMS-1:0]     r_active;
    logic [TW-1:0]            r_ohead, r_otail;
    logic [OW-1:0]            r_ocnt;
    logic [CW-1:0]            r_stk_cnt, r_fresh;
    logic [tq_pkg::MEM_W-1:0] r_member, r_res_mem;
    logic [TW-1:0]            r_t;
    logic [SW-1:0]            r_s;
    logic                     r_same;
    logic                     r_out_valid;
    logic [tq_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [tq_pkg::OUT_USER_W-1:0] r_out_user;

    logic [TW-1:0]            rd_team, rd_order;
    logic [SW-1:0]            rd_head, rd_tail, rd_next, rd_stack;
    logic [tq_pkg::MEM_W-1:0] rd_slot;

    logic [tq_pkg::CMD_W-1:0]  w_in_cmd;
    logic [tq_pkg::MEM_W-1:0]  w_in_member;
    logic [tq_pkg::TEAM_W-1:0] w_in_team;
    logic [MW-1:0]             w_in_idx;
    logic                      w_team_ok;
    logic [CW-1:0]             w_stk_dec;
    logic                      w_from_stack;
    logic [SW-1:0]             w_slot;
    logic                      w_act_t;
    logic                      w_new_team;
    logic [TW-1:0]             w_team_raddr, w_team_waddr;
    logic                      w_head_we, w_tail_we;
    logic [SW-1:0]             w_head_wd, w_tail_wd;
    logic                      w_load_enq_clear;
    logic [TW-1:0]             w_otail_inc, w_ohead_inc;
    logic [tq_pkg::TEAM_W-1:0] w_team_out;

    assign w_in_cmd    = i_in_user;
    assign w_in_member = i_in_data[tq_pkg::MEM_W-1:0];
    assign w_in_team   = i_in_data[tq_pkg::MEM_W +: tq_pkg::TEAM_W];
    assign w_in_idx    = MW'(32'(w_in_member) % MEMBER_IDS);
    assign w_team_ok   = (32'(w_in_team) < MAX_TEAMS);

    assign w_stk_dec    = r_stk_cnt - 1'b1;
    assign w_from_stack = (r_stk_cnt != '0);
    assign w_slot       = w_from_stack ? rd_stack : r_fresh[SW-1:0];
    assign w_act_t      = r_active[rd_team];
    assign w_new_team   = i_cmd.enq_alloc && !w_act_t;

    assign w_team_raddr = i_cmd.deq_team ? rd_order : rd_team;
    assign w_team_waddr = i_cmd.enq_alloc ? rd_team : r_t;
    assign w_head_we    = w_new_team || (i_cmd.deq_pop && !r_same);
    assign w_head_wd    = i_cmd.enq_alloc ? w_slot : rd_next;
    assign w_tail_we    = w_new_team || i_cmd.enq_link;
    assign w_tail_wd    = i_cmd.enq_alloc ? w_slot : r_s;

    assign w_load_enq_clear = i_cmd.load && (w_in_cmd == tq_pkg::CMD_CLEAR);
    assign w_otail_inc = (r_otail == TW'(MAX_TEAMS - 1)) ? '0 : r_otail + 1'b1;
    assign w_ohead_inc = (r_ohead == TW'(MAX_TEAMS - 1)) ? '0 : r_ohead + 1'b1;
    assign w_team_out  = tq_pkg::TEAM_W'(32'(r_t));

    // Memories: registered reads, one write port each
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (w_in_cmd == tq_pkg::CMD_ASSIGN) && w_team_ok) begin
            member_team[w_in_idx] <= TW'(w_in_team);
        end
        rd_team <= member_team[w_in_idx];
    end

    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            team_head[w_team_waddr] <= w_head_wd;
        end
        rd_head <= team_head[w_team_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_tail_we) begin
            team_tail[w_team_waddr] <= w_tail_wd;
        end
        rd_tail <= team_tail[w_team_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_new_team) begin
            order_fifo[r_otail] <= rd_team;
        end
        rd_order <= order_fifo[r_ohead];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_link) begin
            next_link[rd_tail] <= r_s;
        end
        rd_next <= next_link[rd_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enq_alloc) begin
            slot_member[w_slot] <= r_member;
        end
        rd_slot <= slot_member[rd_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.deq_pop) begin
            free_stack[r_stk_cnt[SW-1:0]] <= r_s;
        end
        rd_stack <= free_stack[w_stk_dec[SW-1:0]];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_member <= w_in_member;
        end
        if (i_cmd.enq_alloc) begin
            r_t <= rd_team;
            r_s <= w_slot;
        end
        if (i_cmd.deq_team) begin
            r_t <= rd_order;
        end
        if (i_cmd.deq_slot) begin
            r_s    <= rd_head;
            r_same <= (rd_head == rd_tail);
        end
        if (i_cmd.deq_pop) begin
            r_res_mem <= rd_slot;
        end
        if (i_cmd.res_we) begin
            r_out_data <= i_cmd.res_member
                ? {2'b00, w_team_out, r_res_mem}
                : '0;
            r_out_user <= {i_cmd.res_status, i_cmd.res_member};
        end
    end

    // Control state: team flags, order pointers, pool counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_load_enq_clear) begin
            r_active  <= '0;
            r_ohead   <= '0;
            r_otail   <= '0;
            r_ocnt    <= '0;
            r_stk_cnt <= '0;
            r_fresh   <= '0;
        end else begin
            if (i_cmd.enq_alloc) begin
                if (w_from_stack) begin
                    r_stk_cnt <= w_stk_dec;
                end else begin
                    r_fresh <= r_fresh + 1'b1;
                end
                if (!w_act_t) begin
                    r_active[rd_team] <= 1'b1;
                    r_otail           <= w_otail_inc;
                    r_ocnt            <= r_ocnt + 1'b1;
                end
            end
            if (i_cmd.deq_pop) begin
                r_stk_cnt <= r_stk_cnt + 1'b1;
                if (r_same) begin
                    r_active[r_t] <= 1'b0;
                    r_ohead       <= w_ohead_inc;
                    r_ocnt        <= r_ocnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_we) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.in_cmd      = w_in_cmd;
    assign o_stat.full        = (r_stk_cnt == '0) && (r_fresh == CW'(CAPACITY));
    assign o_stat.empty       = (r_ocnt == '0);
    assign o_stat.team_active = w_act_t;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

@@ src/tq_ctrl.sv @@
// Team queue controller: sequences each item through the pointer memory
// steps and hands the result to the output register. Depends on tq_pkg.
module tq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  tq_pkg::t_dp_stat  i_stat,
    output tq_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ENQ1 = 3'd1;
    localparam logic [2:0] S_ENQ2 = 3'd2;
    localparam logic [2:0] S_DEQ1 = 3'd3;
    localparam logic [2:0] S_DEQ2 = 3'd4;
    localparam logic [2:0] S_DEQ3 = 3'd5;
    localparam logic [2:0] S_RES  = 3'd6;

    logic [2:0]                r_state, n_state;
    logic [tq_pkg::STAT_W-1:0] r_status, n_status;
    logic                      r_member, n_member;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        n_member = r_member;
        o_cmd    = '0;
        o_cmd.res_status = r_status;
        o_cmd.res_member = r_member;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_status   = tq_pkg::STAT_OK;
                    n_member   = 1'b0;
                    n_state    = S_RES;
                    if (i_stat.in_cmd == tq_pkg::CMD_ENQ) begin
                        if (i_stat.full) begin
                            n_status = tq_pkg::STAT_FULL;
                        end else begin
                            n_state = S_ENQ1;
                        end
                    end else if (i_stat.in_cmd == tq_pkg::CMD_DEQ) begin
                        if (i_stat.empty) begin
                            n_status = tq_pkg::STAT_EMPTY;
                        end else begin
                            n_state = S_DEQ1;
                        end
                    end
                end
            end
            S_ENQ1: begin
                o_cmd.enq_alloc = 1'b1;
                n_state = i_stat.team_active ? S_ENQ2 : S_RES;
            end
            S_ENQ2: begin
                o_cmd.enq_link = 1'b1;
                n_state = S_RES;
            end
            S_DEQ1: begin
                o_cmd.deq_team = 1'b1;
                n_state = S_DEQ2;
            end
            S_DEQ2: begin
                o_cmd.deq_slot = 1'b1;
                n_state = S_DEQ3;
            end
            S_DEQ3: begin
                o_cmd.deq_pop = 1'b1;
                n_member = 1'b1;
                n_state  = S_RES;
            end
            S_RES: begin
                // hold until the output register can take the beat
                if (i_stat.out_free) begin
                    o_cmd.res_we = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= tq_pkg::STAT_OK;
            r_member <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_member <= n_member;
        end
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

@@ src/team_queue.sv @@
// Team queue top level: joins the controller and the datapath to the
// stream ports. Depends on tq_pkg, tq_ctrl and tq_datapath.
//
// Members are queued in per-team linked lists inside one pool of CAPACITY
// slots; teams are served in the order they first arrived. Each beat in
// gives exactly one beat out. Assign, clear, a refused enqueue and a
// dequeue on an empty queue go from acceptance straight to the result
// state; an enqueue first allocates a slot and, when the team already has
// members queued, links it to the tail, and a dequeue reads the team order,
// the head slot and then pops it, following the registered reads through
// the member map, team head/tail tables and link memory. One item is in
// work at a time; the next is taken in the cycle after the result has
// moved into the output register, even if that beat is still waiting.
// Clear takes effect at once, with no sweep, and the member map is kept.
module team_queue #(
    parameter int MAX_TEAMS  = 16,
    parameter int MEMBER_IDS = 1024,
    parameter int CAPACITY   = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [9:0] member_id, [13:10] team_id, [15:14] zero
    input  logic [tq_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // [1:0] cmd
    input  logic [tq_pkg::IN_USER_W-1:0]   i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [9:0] member_out, [13:10] team_out, [15:14] zero
    output logic [tq_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // [0] member_valid, [2:1] status
    output logic [tq_pkg::OUT_USER_W-1:0]  o_m_tuser
);

    tq_pkg::t_dp_cmd  w_cmd;
    tq_pkg::t_dp_stat w_stat;

    tq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    tq_datapath #(
        .MAX_TEAMS  (MAX_TEAMS),
        .MEMBER_IDS (MEMBER_IDS),
        .CAPACITY   (CAPACITY)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_data   (i_s_tdata),
        .i_in_user   (i_s_tuser),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata),
        .o_out_user  (o_m_tuser)
    );

endmodule
